// ===== src/rafp_pkg.sv =====
// ----------------------------------------------------------------------------
// rafp_pkg
// shared types and character codes for the tag frame parser
// ----------------------------------------------------------------------------
package rafp_pkg;

    // framing and control characters
    localparam logic [7:0] START_BYTE = 8'h02;
    localparam logic [7:0] END_BYTE   = 8'h03;
    localparam logic [7:0] CR_BYTE    = 8'h0D;
    localparam logic [7:0] LF_BYTE    = 8'h0A;

    // hex digit characters
    localparam logic [7:0] CHAR_0 = 8'h30;
    localparam logic [7:0] CHAR_9 = 8'h39;
    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_F = 8'h46;

    // byte class seen by the frame assembler
    typedef enum logic [1:0] {
        TOK_DATA,
        TOK_SYNC,
        TOK_TERM
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t  kind;
        logic [7:0] value;
    } token_t;

endpackage

// ===== src/rfid_ascii_frame_parser.sv =====
// ----------------------------------------------------------------------------
// rfid_ascii_frame_parser
// ascii-hex tag frame parser with xor check byte
// ----------------------------------------------------------------------------
//
// channel  dir  handshake              payload
// -------  ---  ---------------------  ---------------------------------------
// in       in   in_valid / in_ready    rx_byte[7:0]
// out      out  out_valid / out_ready  tag_id[8*ID_BYTES-1:0], check_byte[7:0],
//                                      checksum_ok
//
// one byte transfer per cycle sustained while the output is not stalled; the
// assembler retires one token per cycle unless stalled, via a combinational
// pack and xor path; out_valid rises once the last character has passed the
// queue entry (written at the transfer edge) and then the result register
// reset clears the frame state, the queue pointers and out_valid
// a stalled output holds the assembler; the two-entry queue keeps taking
// bytes until it fills, then in_ready drops
//
module rfid_ascii_frame_parser
#(
    parameter int ID_BYTES = 5
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            rx_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [8*ID_BYTES-1:0] tag_id,
    output logic [7:0]            check_byte,
    output logic                  checksum_ok
);

    // classified byte entering the queue
    rafp_pkg::token_t in_token;

    // queue head toward the assembler
    rafp_pkg::token_t head_token;
    logic             token_valid;
    logic             token_ready;

    // front: byte classification, stateless
    rafp_classify u_classify
    (
        .rx_byte (rx_byte),
        .token   (in_token)
    );

    // queue decouples the byte stream from output stalls
    rafp_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_data  (in_token),
        .pop_valid  (token_valid),
        .pop_ready  (token_ready),
        .pop_data   (head_token)
    );

    // back: frame tracking, byte packing and the result register
    rafp_assemble #(
        .ID_BYTES (ID_BYTES)
    ) u_assemble
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .token       (head_token),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .tag_id      (tag_id),
        .check_byte  (check_byte),
        .checksum_ok (checksum_ok)
    );

    // a byte transfer always leaves the queue non-empty
    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> token_valid)
        else $error("queue empty after byte transfer");

    // the queue only refuses bytes when it holds tokens
    a_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> token_valid)
        else $error("queue refuses bytes while empty");

    // a stalled result blocks the assembler
    a_stall_holds_back: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !token_ready)
        else $error("assembler advances over a stalled result");

endmodule

// ===== src/rafp_classify.sv =====
// ----------------------------------------------------------------------------
// rafp_classify
// sorts a received byte into sync, terminator or data and maps hex digits
// ----------------------------------------------------------------------------
module rafp_classify
(
    input  logic [7:0]      rx_byte,
    output rafp_pkg::token_t token
);

    always_comb
    begin
        token.kind  = rafp_pkg::TOK_DATA;
        token.value = rx_byte;
        if (rx_byte == rafp_pkg::START_BYTE)
        begin
            token.kind = rafp_pkg::TOK_SYNC;
        end
        else if (rx_byte == rafp_pkg::END_BYTE || rx_byte == rafp_pkg::CR_BYTE
                 || rx_byte == rafp_pkg::LF_BYTE)
        begin
            token.kind = rafp_pkg::TOK_TERM;
        end
        else if (rx_byte >= rafp_pkg::CHAR_0 && rx_byte <= rafp_pkg::CHAR_9)
        begin
            token.value = rx_byte - rafp_pkg::CHAR_0;
        end
        else if (rx_byte >= rafp_pkg::CHAR_A && rx_byte <= rafp_pkg::CHAR_F)
        begin
            // 'A' maps to ten
            token.value = rx_byte - rafp_pkg::CHAR_A + 8'd10;
        end
    end

endmodule

// ===== src/rafp_fifo.sv =====
// ----------------------------------------------------------------------------
// rafp_fifo
// two-entry token queue between classifier and frame assembler
// ----------------------------------------------------------------------------
module rafp_fifo
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  rafp_pkg::token_t push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output rafp_pkg::token_t pop_data
);

    localparam int DEPTH = 2;

    rafp_pkg::token_t entry_reg [DEPTH];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != 2'(DEPTH));
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/rafp_assemble.sv =====
// ----------------------------------------------------------------------------
// rafp_assemble
// frame state machine: packs nibble pairs, builds the tag and checks the xor
// ----------------------------------------------------------------------------
module rafp_assemble
#(
    parameter int ID_BYTES = 5
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    token_valid,
    output logic                    token_ready,
    input  rafp_pkg::token_t        token,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [8*ID_BYTES-1:0]   tag_id,
    output logic [7:0]              check_byte,
    output logic                    checksum_ok
);

    localparam int FRAME_CHARS = 2 * (ID_BYTES + 1);
    localparam int CNT_W       = $clog2(FRAME_CHARS);
    localparam int TAG_W       = 8 * ID_BYTES;

    typedef enum logic {
        ST_IDLE,
        ST_FRAME
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [3:0]          pending_reg;
    logic [3:0]          pending_next;
    logic [7:0]          frame_bytes_reg [ID_BYTES];
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [TAG_W-1:0]    tag_id_reg;
    logic [TAG_W-1:0]    tag_id_next;
    logic [7:0]          check_byte_reg;
    logic [7:0]          check_byte_next;
    logic                checksum_ok_reg;
    logic                checksum_ok_next;
    logic                take;
    logic                byte_write;
    logic [CNT_W-2:0]    byte_idx;
    logic [7:0]          packed_byte;
    logic [7:0]          id_xor;

    assign token_ready = !out_valid_reg || out_ready;
    assign take        = token_valid && token_ready;
    assign byte_idx    = count_reg[CNT_W-1:1];
    assign packed_byte = {pending_reg, 4'b0000} | token.value;

    assign out_valid   = out_valid_reg;
    assign tag_id      = tag_id_reg;
    assign check_byte  = check_byte_reg;
    assign checksum_ok = checksum_ok_reg;

    always_comb
    begin
        id_xor = 8'd0;
        tag_id_next = '0;
        for (int i = 0; i < ID_BYTES; i++)
        begin
            id_xor = id_xor ^ frame_bytes_reg[i];
            tag_id_next[8*(ID_BYTES-1-i) +: 8] = frame_bytes_reg[i];
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        pending_next     = pending_reg;
        byte_write       = 1'b0;
        out_valid_next   = out_valid_reg && !out_ready;
        check_byte_next  = check_byte_reg;
        checksum_ok_next = checksum_ok_reg;
        if (take)
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (token.kind == rafp_pkg::TOK_SYNC)
                    begin
                        state_next = ST_FRAME;
                        count_next = '0;
                    end
                end
                ST_FRAME:
                begin
                    case (token.kind)
                        rafp_pkg::TOK_DATA:
                        begin
                            if (count_reg[0])
                            begin
                                byte_write = 1'b1;
                            end
                            else
                            begin
                                pending_next = token.value[3:0];
                            end
                            if (count_reg == CNT_W'(FRAME_CHARS - 1))
                            begin
                                // last char closes the check byte
                                state_next       = ST_IDLE;
                                count_next       = '0;
                                out_valid_next   = 1'b1;
                                check_byte_next  = packed_byte;
                                checksum_ok_next = (id_xor == packed_byte);
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        default:
                        begin
                            // sync or terminator inside a frame aborts it
                            state_next = ST_IDLE;
                            count_next = '0;
                        end
                    endcase
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            pending_reg     <= 4'd0;
            out_valid_reg   <= 1'b0;
            tag_id_reg      <= '0;
            check_byte_reg  <= 8'd0;
            checksum_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            pending_reg     <= pending_next;
            out_valid_reg   <= out_valid_next;
            check_byte_reg  <= check_byte_next;
            checksum_ok_reg <= checksum_ok_next;
            if (take && out_valid_next && !(out_valid_reg && !out_ready))
            begin
                tag_id_reg <= tag_id_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ID_BYTES; i++)
        begin
            if (byte_write && byte_idx == (CNT_W-1)'(i))
            begin
                frame_bytes_reg[i] <= packed_byte;
            end
        end
    end

endmodule
